### design/smws_pkg.sv
// ----------------------------------------------------------------------------
// smws_pkg: shared definitions for the sorted matrix window search unit
// Field widths, operation codes and index type used at the ports.
// ----------------------------------------------------------------------------
package smws_pkg;

    // Width of the row and column fields of a word.
    localparam int IDX_W = 4;

    // Width of the value field of an input word (two's complement).
    localparam int IN_VALUE_W = 32;

    // Operation codes carried by the func field.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [IN_VALUE_W-1:0] t_in_value;

endpackage

### design/smws_ram.sv
// ----------------------------------------------------------------------------
// smws_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/sorted_matrix_window_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_matrix_window_search_unit: staircase search over a sorted matrix
// Holds a MAX_ROWS x MAX_COLS matrix of signed cells in one RAM and searches
// a row/column window of it for a target value.
// ----------------------------------------------------------------------------
// A write word (func = write) stores search_value, sign-adjusted to
// VALUE_WIDTH bits, at (row_lo, col_lo); it gives no
// result, and a write outside the matrix is dropped. A query word gives one
// result word: found with the row and column of the hit, or found = 0 with
// zero coordinates once the window is empty. Window bounds saturate at the
// last row and column. Every cell the query touches must have been written
// before; unwritten cells read back as garbage. A query reads one cell per
// cycle through the single read port of the cell RAM. The unit works on one
// query at a time and takes no new word until the query result has moved
// into the output register, which holds it until the consumer takes it;
// writes are accepted while a result still waits. Writes land only while
// the search is idle, so a search read never races a write to the same cell.
module sorted_matrix_window_search_unit #(
    parameter int MAX_ROWS    = 16,
    parameter int MAX_COLS    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  smws_pkg::t_idx       i_row_lo,
    input  smws_pkg::t_idx       i_row_hi,
    input  smws_pkg::t_idx       i_col_lo,
    input  smws_pkg::t_idx       i_col_hi,
    input  smws_pkg::t_in_value  i_search_value,
    // result word channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_found,
    output smws_pkg::t_idx       o_hit_row,
    output smws_pkg::t_idx       o_hit_col
);

    import smws_pkg::*;

    // Index widths; the window registers carry two extra bits so that a
    // bound can step one past either end and compare as signed.
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW_R = RW + 2;
    localparam int RCW_C = CW + 2;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic signed [RCW_R-1:0] ONE_R = 1;
    localparam logic signed [RCW_C-1:0] ONE_C = 1;

    // Sequencer codes. Each read state (..C, L*) sees the cell that the
    // previous cycle addressed.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TL   = 4'd1;  // empty check, address top-left
    localparam logic [3:0] S_TLC  = 4'd2;  // test top-left
    localparam logic [3:0] S_TRC  = 4'd3;  // test top-right
    localparam logic [3:0] S_BLC  = 4'd4;  // test bottom-left, then drop columns
    localparam logic [3:0] S_L1   = 4'd5;  // drop columns with bottom below target
    localparam logic [3:0] S_L2   = 4'd6;  // drop columns with top above target
    localparam logic [3:0] S_L3   = 4'd7;  // drop rows with right below target
    localparam logic [3:0] S_L4   = 4'd8;  // drop rows with left above target
    localparam logic [3:0] S_DONE = 4'd9;  // hand result to output register

    // Saturate a window bound at the last row or column.
    function automatic logic [9:0] clamp_idx(t_idx v, int limit);
        logic [9:0] w;
        w = 10'(v);
        if (w >= 10'(limit)) begin
            w = 10'(limit - 1);
        end
        return w;
    endfunction

    // Row-major cell address.
    function automatic logic [AW-1:0] cell_addr(logic [9:0] row, logic [9:0] col);
        logic [17:0] a;
        a = 18'(row[RW-1:0]) * 18'(MAX_COLS) + 18'(col[CW-1:0]);
        return a[AW-1:0];
    endfunction

    function automatic t_idx low_idx(logic [9:0] v);
        return v[IDX_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]                    r_state, n_state;
    logic signed [RCW_R-1:0]       r_rs, n_rs, r_re, n_re;
    logic signed [RCW_C-1:0]       r_cs, n_cs, r_ce, n_ce;
    logic signed [VALUE_WIDTH-1:0] r_key, n_key;
    logic                          r_res_found, n_res_found;
    t_idx                          r_res_row, n_res_row, r_res_col, n_res_col;
    logic                          r_out_valid;
    logic                          r_found;
    t_idx                          r_hit_row, r_hit_col;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic                          w_in_accept;
    logic signed [63:0]            w_ext;
    logic signed [VALUE_WIDTH-1:0] w_key;
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic                          w_out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_accept = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Sign-extend the 32-bit field, then keep VALUE_WIDTH bits.
    assign w_ext = {{32{i_search_value[IN_VALUE_W-1]}}, i_search_value};
    assign w_key = $signed(w_ext[VALUE_WIDTH-1:0]);

    // Drop writes outside the matrix.
    assign w_wr_en = w_in_accept && (i_func == FUNC_WRITE)
                     && (10'(i_row_lo) < 10'(MAX_ROWS))
                     && (10'(i_col_lo) < 10'(MAX_COLS));
    assign w_wr_addr = cell_addr(10'(i_row_lo), 10'(i_col_lo));

    // ------------------------------------------------------------------
    // Cell RAM
    // ------------------------------------------------------------------
    logic                          w_rd_en;
    logic signed [RCW_R-1:0]       w_rd_row;
    logic signed [RCW_C-1:0]       w_rd_col;
    logic [AW-1:0]                 w_rd_addr;
    logic [VALUE_WIDTH-1:0]        w_rd_raw;
    logic signed [VALUE_WIDTH-1:0] w_cell;

    assign w_rd_addr = cell_addr(10'(w_rd_row), 10'(w_rd_col));
    assign w_cell    = $signed(w_rd_raw);

    smws_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_cell_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_key),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    // ------------------------------------------------------------------
    // Search sequencer
    // ------------------------------------------------------------------
    logic                    w_eq, w_lt, w_gt;
    logic signed [RCW_R-1:0] w_rs_inc, w_re_dec;
    logic signed [RCW_C-1:0] w_cs_inc, w_ce_dec;

    assign w_eq = (w_cell == r_key);
    assign w_lt = (w_cell <  r_key);
    assign w_gt = (w_cell >  r_key);
    assign w_rs_inc = r_rs + ONE_R;
    assign w_re_dec = r_re - ONE_R;
    assign w_cs_inc = r_cs + ONE_C;
    assign w_ce_dec = r_ce - ONE_C;

    always_comb begin
        n_state     = r_state;
        n_rs        = r_rs;
        n_re        = r_re;
        n_cs        = r_cs;
        n_ce        = r_ce;
        n_key       = r_key;
        n_res_found = r_res_found;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        w_rd_en     = 1'b0;
        w_rd_row    = r_rs;
        w_rd_col    = r_cs;

        unique case (r_state) inside
            S_IDLE: begin
                if (w_in_accept && (i_func == FUNC_QUERY)) begin
                    n_rs    = $signed(RCW_R'(clamp_idx(i_row_lo, MAX_ROWS)));
                    n_re    = $signed(RCW_R'(clamp_idx(i_row_hi, MAX_ROWS)));
                    n_cs    = $signed(RCW_C'(clamp_idx(i_col_lo, MAX_COLS)));
                    n_ce    = $signed(RCW_C'(clamp_idx(i_col_hi, MAX_COLS)));
                    n_key   = w_key;
                    n_state = S_TL;
                end
            end
            S_TL: begin
                if ((r_rs > r_re) || (r_cs > r_ce)) begin
                    n_res_found = 1'b0;
                    n_res_row   = '0;
                    n_res_col   = '0;
                    n_state     = S_DONE;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_row = r_rs;
                    w_rd_col = r_cs;
                    n_state  = S_TLC;
                end
            end
            S_TLC: begin
                if (w_eq) begin
                    n_res_found = 1'b1;
                    n_res_row   = low_idx(10'(r_rs));
                    n_res_col   = low_idx(10'(r_cs));
                    n_state     = S_DONE;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_row = r_rs;
                    w_rd_col = r_ce;
                    n_state  = S_TRC;
                end
            end
            S_TRC: begin
                if (w_eq) begin
                    n_res_found = 1'b1;
                    n_res_row   = low_idx(10'(r_rs));
                    n_res_col   = low_idx(10'(r_ce));
                    n_state     = S_DONE;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_row = r_re;
                    w_rd_col = r_cs;
                    n_state  = S_BLC;
                end
            end
            S_BLC, S_L1: begin
                if ((r_state == S_BLC) && w_eq) begin
                    n_res_found = 1'b1;
                    n_res_row   = low_idx(10'(r_re));
                    n_res_col   = low_idx(10'(r_cs));
                    n_state     = S_DONE;
                end else if (w_lt) begin
                    // drop this column; read the next bottom cell if any
                    n_cs = w_cs_inc;
                    if (w_cs_inc <= r_ce) begin
                        w_rd_en  = 1'b1;
                        w_rd_row = r_re;
                        w_rd_col = w_cs_inc;
                        n_state  = S_L1;
                    end else begin
                        n_state = S_TL;
                    end
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_row = r_rs;
                    w_rd_col = r_ce;
                    n_state  = S_L2;
                end
            end
            S_L2: begin
                if (w_gt) begin
                    n_ce = w_ce_dec;
                    if (r_cs <= w_ce_dec) begin
                        w_rd_en  = 1'b1;
                        w_rd_row = r_rs;
                        w_rd_col = w_ce_dec;
                    end else begin
                        n_state = S_TL;
                    end
                end else begin
                    // rows are untouched this pass, so the window still holds rows
                    w_rd_en  = 1'b1;
                    w_rd_row = r_rs;
                    w_rd_col = r_ce;
                    n_state  = S_L3;
                end
            end
            S_L3: begin
                if (w_lt) begin
                    n_rs = w_rs_inc;
                    if (w_rs_inc <= r_re) begin
                        w_rd_en  = 1'b1;
                        w_rd_row = w_rs_inc;
                        w_rd_col = r_ce;
                    end else begin
                        n_state = S_TL;
                    end
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_row = r_re;
                    w_rd_col = r_cs;
                    n_state  = S_L4;
                end
            end
            S_L4: begin
                if (w_gt) begin
                    n_re = w_re_dec;
                    if (r_rs <= w_re_dec) begin
                        w_rd_en  = 1'b1;
                        w_rd_row = w_re_dec;
                        w_rd_col = r_cs;
                    end else begin
                        n_state = S_TL;
                    end
                end else begin
                    n_state = S_TL;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window, target and result payload
    always_ff @(posedge i_clk) begin
        r_rs        <= n_rs;
        r_re        <= n_re;
        r_cs        <= n_cs;
        r_ce        <= n_ce;
        r_key       <= n_key;
        r_res_found <= n_res_found;
        r_res_row   <= n_res_row;
        r_res_col   <= n_res_col;
        if ((r_state == S_DONE) && w_out_free) begin
            r_found   <= r_res_found;
            r_hit_row <= r_res_row;
            r_hit_col <= r_res_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_hit_row   = r_hit_row;
    assign o_hit_col   = r_hit_col;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rd_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (w_rd_row >= 0) && (w_rd_row < RCW_R'(MAX_ROWS))
                    && (w_rd_col >= 0) && (w_rd_col < RCW_C'(MAX_COLS)))
        else $error("search read outside the matrix");

    a_no_wr_during_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("cell write overlaps a search read");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> o_out_valid && (r_state == S_IDLE))
        else $error("finished query did not reach the output register");

    a_miss_zero_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_hit_row == '0) && (o_hit_col == '0))
        else $error("not-found result carries nonzero coordinates");

endmodule
